[rtl/core/lamp_matrix_glow_dimmer_unit_macros.svh]
// assertion helpers for the glow dimmer
`ifndef LAMP_MATRIX_GLOW_DIMMER_UNIT_MACROS_SVH
`define LAMP_MATRIX_GLOW_DIMMER_UNIT_MACROS_SVH

// same-cycle implication
`define LMGD_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define LMGD_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

[rtl/core/lmgd_pkg.sv]
// ----------------------------------------------------------------------------
// lmgd_pkg
// Types and constants shared by the glow dimmer lanes and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lmgd_pkg;

    localparam logic [4:0]  HOLD_MS        = 5'd22;
    localparam logic [15:0] SHORT_PULSE_MS = 16'd32;
    localparam logic [15:0] TIMER_MAX      = 16'hFFFF;

    localparam logic REQ_SETTINGS = 1'b0;
    localparam logic REQ_COLUMN   = 1'b1;

    localparam logic CFG_IDX_INTERVAL = 1'b0;
    localparam logic CFG_IDX_HOLD     = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  column;
        logic [3:0]  row;
        logic [9:0]  raw_rows;
        logic [31:0] step_up;
        logic [31:0] step_down;
        logic [31:0] max_level;
        logic [15:0] on_delay_ms;
    } in_item_t;

    typedef struct packed {
        logic [2:0] out_column;
        logic [7:0] level_r0;
        logic [7:0] level_r1;
        logic [7:0] level_r2;
        logic [7:0] level_r3;
        logic [7:0] level_r4;
        logic [7:0] level_r5;
        logic [7:0] level_r6;
        logic [7:0] level_r7;
        logic [7:0] level_r8;
        logic [7:0] level_r9;
    } out_item_t;

    typedef struct packed {
        logic [31:0] step_up;
        logic [31:0] step_down;
        logic [31:0] max_level;
        logic [15:0] on_delay_ms;
    } lamp_set_t;

    // control from the top level to every lane; all but set_en is shared
    typedef struct packed {
        logic       upd_en;
        logic       set_en;
        logic [7:0] interval;
        logic       hold_mode;
    } lane_ctrl_t;

endpackage
`default_nettype wire

[rtl/core/lmgd_lane.sv]
// ----------------------------------------------------------------------------
// lmgd_lane
// One matrix row: per-column lamp state and its read-modify-write update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lmgd_lane #(
    parameter int NUM_COLUMNS = 8,
    parameter int COL_W       = 3
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lmgd_pkg::lane_ctrl_t ctrl,
    input  wire logic [COL_W-1:0]    col,
    input  wire logic                lit,
    input  wire lmgd_pkg::lamp_set_t settings,
    output logic [7:0]               level
);

    logic [31:0] bright_reg [NUM_COLUMNS];
    logic [15:0] on_reg     [NUM_COLUMNS];
    logic [15:0] off_reg    [NUM_COLUMNS];
    logic [4:0]  hold_reg   [NUM_COLUMNS];
    lmgd_pkg::lamp_set_t set_reg [NUM_COLUMNS];

    logic [31:0] bright_next;
    logic [15:0] on_next, off_next;
    logic [4:0]  hold_next;

    logic [31:0] br, pk_gap;
    logic [15:0] on_t, off_t;
    logic [4:0]  hd, hd_dec;
    logic [16:0] on_sum, off_sum;
    lmgd_pkg::lamp_set_t st;

    always_comb
    begin
        br      = bright_reg[col];
        on_t    = on_reg[col];
        off_t   = off_reg[col];
        hd      = hold_reg[col];
        st      = set_reg[col];
        pk_gap  = st.max_level - st.step_up;
        on_sum  = {1'b0, on_t} + {9'd0, ctrl.interval};
        off_sum = {1'b0, off_t} + {9'd0, ctrl.interval};
        hd_dec  = ({3'd0, hd} > ctrl.interval) ? (hd - ctrl.interval[4:0]) : 5'd0;

        bright_next = br;
        on_next     = on_t;
        off_next    = off_t;
        hold_next   = hd;
        if (lit)
        begin
            if (on_t >= st.on_delay_ms)
            begin
                if (st.step_up <= st.max_level && br < pk_gap)
                    bright_next = br + st.step_up;
                else
                    bright_next = st.max_level;
            end
            on_next   = on_sum[16] ? lmgd_pkg::TIMER_MAX : on_sum[15:0];
            off_next  = 16'd0;
            hold_next = 5'd0;
        end
        else
        begin
            hold_next = hd_dec;
            // short pulse just ended: hold before fading
            if (off_t == 16'd0 && ctrl.hold_mode && on_t < lmgd_pkg::SHORT_PULSE_MS)
                hold_next = lmgd_pkg::HOLD_MS;
            if (off_t >= {11'd0, hold_next})
                bright_next = (br > st.step_down) ? (br - st.step_down) : 32'd0;
            off_next = off_sum[16] ? lmgd_pkg::TIMER_MAX : off_sum[15:0];
            on_next  = 16'd0;
        end
    end

    assign level = bright_next[31:24];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_COLUMNS; c++)
            begin
                bright_reg[c] <= '0;
                on_reg[c]     <= '0;
                off_reg[c]    <= '0;
                hold_reg[c]   <= '0;
            end
        end
        else if (ctrl.upd_en)
        begin
            bright_reg[col] <= bright_next;
            on_reg[col]     <= on_next;
            off_reg[col]    <= off_next;
            hold_reg[col]   <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.set_en)
            set_reg[col] <= settings;
    end

endmodule
`default_nettype wire

[rtl/core/lamp_matrix_glow_dimmer_unit.sv]
// ----------------------------------------------------------------------------
// lamp_matrix_glow_dimmer_unit
// Per-lamp glow dimmer, one lane per row, merged into one column result.
// ----------------------------------------------------------------------------
// Each item is first registered in the item register; once it fires, every row
// lane does its read-modify-write of the addressed column and the merged levels
// land in the output register (a settings item writes only the addressed row's
// lane). A new item is taken once the lane cycle is done; a column update waits
// in the item register while an earlier result is still not taken. Settings
// writes and out-of-range columns give no result.
`timescale 1ns / 1ps
`default_nettype none
`include "lamp_matrix_glow_dimmer_unit_macros.svh"
module lamp_matrix_glow_dimmer_unit #(
    parameter int NUM_COLUMNS = 8,
    parameter int NUM_ROWS    = 10
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_addr,
    input  wire logic [7:0]           cfg_wdata,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire lmgd_pkg::in_item_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output lmgd_pkg::out_item_t       out_data
);

    localparam int COL_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

    logic [7:0] interval_reg;
    logic       hold_mode_reg;
    logic       busy_reg, busy_next;
    logic       out_valid_reg, out_valid_next;
    lmgd_pkg::in_item_t  item_reg;
    lmgd_pkg::out_item_t out_reg, out_next;

    logic              fire, col_ok, row_ok, is_upd;
    logic [COL_W+2:0]  col_wide;
    logic [COL_W-1:0]  col_idx;
    logic [7:0]        lvl [10];
    lmgd_pkg::lane_ctrl_t ctrl;
    lmgd_pkg::lamp_set_t  settings;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= 8'd1;
            hold_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                lmgd_pkg::CFG_IDX_INTERVAL: interval_reg  <= cfg_wdata;
                lmgd_pkg::CFG_IDX_HOLD:     hold_mode_reg <= cfg_wdata[0];
                default:                    interval_reg  <= interval_reg;
            endcase
        end
    end

    assign in_ready = !busy_reg;
    assign col_wide = {{COL_W{1'b0}}, item_reg.column};
    assign col_idx  = col_wide[COL_W-1:0];
    assign col_ok   = ({29'd0, item_reg.column} < NUM_COLUMNS);
    assign row_ok   = ({28'd0, item_reg.row} < NUM_ROWS);
    assign is_upd   = (item_reg.req_type == lmgd_pkg::REQ_COLUMN);
    assign fire     = busy_reg && (!is_upd || !out_valid_reg || out_ready);

    assign ctrl.upd_en    = fire && is_upd && col_ok;
    assign ctrl.set_en    = 1'b0;
    assign ctrl.interval  = interval_reg;
    assign ctrl.hold_mode = hold_mode_reg;

    assign settings.step_up     = item_reg.step_up;
    assign settings.step_down   = item_reg.step_down;
    assign settings.max_level   = item_reg.max_level;
    assign settings.on_delay_ms = item_reg.on_delay_ms;

    for (genvar r = 0; r < 10; r++)
    begin : g_lane
        if (r < NUM_ROWS)
        begin : g_on
            lmgd_pkg::lane_ctrl_t lane_ctrl;
            always_comb
            begin
                lane_ctrl        = ctrl;
                lane_ctrl.set_en = fire && !is_upd && col_ok && row_ok
                                   && (item_reg.row == 4'(r));
            end
            lmgd_lane #(
                .NUM_COLUMNS(NUM_COLUMNS),
                .COL_W      (COL_W)
            ) u_lane (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (lane_ctrl),
                .col     (col_idx),
                .lit     (item_reg.raw_rows[r]),
                .settings(settings),
                .level   (lvl[r])
            );
        end
        else
        begin : g_off
            assign lvl[r] = 8'd0;
        end
    end

    // merge the lanes into one result, and work out the next busy and output-valid state
    always_comb
    begin
        out_next            = out_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        busy_next           = busy_reg;
        if (ctrl.upd_en)
        begin
            out_next.out_column = item_reg.column;
            out_next.level_r0   = lvl[0];
            out_next.level_r1   = lvl[1];
            out_next.level_r2   = lvl[2];
            out_next.level_r3   = lvl[3];
            out_next.level_r4   = lvl[4];
            out_next.level_r5   = lvl[5];
            out_next.level_r6   = lvl[6];
            out_next.level_r7   = lvl[7];
            out_next.level_r8   = lvl[8];
            out_next.level_r9   = lvl[9];
            out_valid_next      = 1'b1;
        end
        priority if (in_valid && in_ready)
            busy_next = 1'b1;
        else if (fire)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_data;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `LMGD_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, busy_reg)
    `LMGD_ASSERT_NOW(a_busy_blocks, clk, rst_n, busy_reg, !in_ready)
    `LMGD_ASSERT_NOW(a_out_from_lanes, clk, rst_n, $rose(out_valid_reg), $past(busy_reg))

endmodule
`default_nettype wire
